// File: sv/ffha_pkg.sv
// Package for the first-fit heap allocator.
// Holds the status and operation codes, the need field width and default sizes; depends on nothing.
`default_nettype none

package ffha_pkg;

	localparam int HEAP_BYTES_DEF   = 65536;
	localparam int MAX_BLOCKS_DEF   = 256;
	localparam int HEADER_BYTES_DEF = 8;

	// A need is a 16-bit request plus a header; 17 bits hold it for a header of at most 65536 bytes.
	localparam int NEED_W = 17;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_EXHAUSTED  = 2'd1;
	localparam logic [1:0] ST_TABLE_FULL = 2'd2;
	localparam logic [1:0] ST_UNKNOWN    = 2'd3;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

endpackage

`default_nettype wire

// File: sv/ffha_table.sv
// Block table memory of the first-fit heap allocator.
// One write port and one registered read port; uses ffha_pkg for its default depth and width.
`default_nettype none

module ffha_table
	import ffha_pkg::*;
#(
	parameter int DEPTH = MAX_BLOCKS_DEF,
	parameter int WIDTH = 1 + 2 * NEED_W
) (
	input  wire logic                     clk,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_idx,
	output logic      [WIDTH-1:0]         rd_entry,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_idx,
	input  wire logic [WIDTH-1:0]         wr_entry
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_entry <= mem[rd_idx];
		end
	end

endmodule

`default_nettype wire

// File: sv/first_fit_heap_allocator_core.sv
// First-fit heap allocator: a table walk over a one-port-read memory, then at most one write-back.
// A start is taken only while idle, so each item ends before the next one begins.
// The walk reads one entry per cycle; done pulses for one cycle per result, never held off.
// Reset clears the entry count, the break and the base; the table needs no clearing pass.
// Depends on ffha_pkg and ffha_table.
`default_nettype none

module first_fit_heap_allocator_core
	import ffha_pkg::*;
#(
	parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
	parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        operation,
	input  wire logic [15:0] request_bytes,
	input  wire logic [31:0] free_address,
	output logic             done,
	output logic      [31:0] address,
	output logic      [1:0]  status
);

	localparam int OFF_W = $clog2(HEAP_BYTES);
	localparam int BRK_W = $clog2(HEAP_BYTES + 1);
	localparam int IDX_W = $clog2(MAX_BLOCKS);
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam int ENT_W = 1 + NEED_W + OFF_W;
	localparam int CMP_W = ((BRK_W > NEED_W) ? BRK_W : NEED_W) + 1;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_WALK = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0]        state_q;
	logic [31:0]       heap_base_q;
	logic [CNT_W-1:0]  total_q;
	logic [BRK_W-1:0]  break_q;
	logic              op_q;
	logic [NEED_W-1:0] need_q;
	logic [31:0]       target_q;
	logic [CNT_W-1:0]  rd_cnt_q;
	logic              chk_v_s1;
	logic [IDX_W-1:0]  chk_idx_s1;
	logic              found_q;
	logic [IDX_W-1:0]  hit_idx_q;
	logic [ENT_W-1:0]  hit_entry_q;
	logic              done_q;
	logic [31:0]       address_q;
	logic [1:0]        status_q;

	logic              rd_en;
	logic [ENT_W-1:0]  rd_entry;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_idx;
	logic [ENT_W-1:0]  wr_entry;

	logic              ent_avail;
	logic [NEED_W-1:0] ent_len;
	logic [OFF_W-1:0]  ent_off;
	logic              hit_now;
	logic              end_now;
	logic [CMP_W-1:0]  break_sum;
	logic              over;
	logic              table_full;
	logic [OFF_W-1:0]  grant_off;
	logic [31:0]       grant_addr;

	assign ent_avail = rd_entry[ENT_W-1];
	assign ent_len   = rd_entry[NEED_W+OFF_W-1:OFF_W];
	assign ent_off   = rd_entry[OFF_W-1:0];

	assign rd_en   = (state_q == S_WALK) && (rd_cnt_q != total_q);
	assign hit_now = (state_q == S_WALK) && chk_v_s1 &&
		((op_q == OP_ALLOC) ? (ent_avail && (ent_len >= need_q))
		                    : (32'(ent_off) == target_q));
	assign end_now = (state_q == S_WALK) && !chk_v_s1 && (rd_cnt_q == total_q);

	assign break_sum  = CMP_W'(break_q) + CMP_W'(need_q);
	assign over       = break_sum > CMP_W'(HEAP_BYTES);
	assign table_full = total_q == CNT_W'(MAX_BLOCKS);
	assign grant_off  = found_q ? hit_entry_q[OFF_W-1:0] : break_q[OFF_W-1:0];
	assign grant_addr = heap_base_q + 32'(grant_off) + 32'(HEADER_BYTES);

	always_comb begin
		wr_en    = 1'b0;
		wr_idx   = hit_idx_q;
		wr_entry = {op_q == OP_FREE, hit_entry_q[ENT_W-2:0]};
		if (state_q == S_DONE) begin
			if (found_q) begin
				wr_en = 1'b1;
			end else if (op_q == OP_ALLOC && !table_full && !over) begin
				wr_en    = 1'b1;
				wr_idx   = total_q[IDX_W-1:0];
				wr_entry = {1'b0, need_q, break_q[OFF_W-1:0]};
			end
		end
	end

	ffha_table #(
		.DEPTH(MAX_BLOCKS),
		.WIDTH(ENT_W)
	) u_table (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_idx  (rd_cnt_q[IDX_W-1:0]),
		.rd_entry(rd_entry),
		.wr_en   (wr_en),
		.wr_idx  (wr_idx),
		.wr_entry(wr_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			heap_base_q <= '0;
			total_q     <= '0;
			break_q     <= '0;
			rd_cnt_q    <= '0;
			chk_v_s1    <= 1'b0;
			found_q     <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q   <= 1'b0;
			chk_v_s1 <= rd_en;
			if (cfg_we) begin
				heap_base_q <= cfg_wdata;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						rd_cnt_q <= '0;
						state_q  <= S_WALK;
					end
				end
				S_WALK: begin
					if (rd_en) begin
						rd_cnt_q <= rd_cnt_q + CNT_W'(1);
					end
					if (hit_now) begin
						found_q <= 1'b1;
						state_q <= S_DONE;
					end else if (end_now) begin
						found_q <= 1'b0;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
					if (!found_q && op_q == OP_ALLOC && !table_full && !over) begin
						total_q <= total_q + CNT_W'(1);
						break_q <= break_sum[BRK_W-1:0];
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		chk_idx_s1 <= rd_cnt_q[IDX_W-1:0];
		if (state_q == S_IDLE && start) begin
			op_q     <= operation;
			need_q   <= NEED_W'(request_bytes) + NEED_W'(HEADER_BYTES);
			target_q <= free_address - heap_base_q - 32'(HEADER_BYTES);
		end
		if (hit_now) begin
			hit_idx_q   <= chk_idx_s1;
			hit_entry_q <= rd_entry;
		end
		if (state_q == S_DONE) begin
			address_q <= '0;
			status_q  <= ST_OK;
			if (op_q == OP_ALLOC) begin
				if (found_q) begin
					address_q <= grant_addr;
				end else if (table_full) begin
					status_q <= ST_TABLE_FULL;
				end else if (over) begin
					status_q <= ST_EXHAUSTED;
				end else begin
					address_q <= grant_addr;
				end
			end else if (!found_q) begin
				status_q <= ST_UNKNOWN;
			end
		end
	end

	assign busy    = state_q != S_IDLE;
	assign done    = done_q;
	assign address = address_q;
	assign status  = status_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while still busy");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted transaction did not start");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CNT_W'(MAX_BLOCKS)) else $error("block count beyond table size");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> address == 32'd0)
		else $error("failed transaction returned an address");

endmodule

`default_nettype wire

// File: test/tb_first_fit_heap_allocator_core.sv
// Testbench for first_fit_heap_allocator_core: each transaction is predicted by a scoreboard
// that keeps its own block table, break and heap base, and every result is checked in order.
// Depends on ffha_pkg and the allocator RTL; needs nothing else.

module tb_first_fit_heap_allocator_core;
	timeunit 1ns;
	timeprecision 1ps;

	import ffha_pkg::*;

	localparam int HEAP   = HEAP_BYTES_DEF;
	localparam int BLOCKS = MAX_BLOCKS_DEF;
	localparam int HDR    = HEADER_BYTES_DEF;

	typedef struct packed {
		logic [31:0] address;
		logic [1:0]  status;
	} heap_result_t;

	class heap_scoreboard;
		logic [31:0]  base = '0;
		logic [15:0]  blk_off [BLOCKS];
		logic [16:0]  blk_len [BLOCKS];
		bit           blk_free [BLOCKS];
		int unsigned  n_blocks = 0;
		int unsigned  brk = 0;
		heap_result_t pending_q [$];
		int           errors = 0;

		function logic [31:0] user_addr(int unsigned idx);
			return base + 32'(blk_off[idx]) + 32'(HDR);
		endfunction

		task report(string what);
			$display("MISMATCH at %0t: %s", $realtime, what);
			errors++;
		endtask

		function void note_request(logic op, logic [15:0] req, logic [31:0] fa);
			heap_result_t r;
			int unsigned  need;
			bit           found;
			r.address = '0;
			r.status = ST_OK;
			found = 1'b0;
			need = 32'(req) + HDR;
			if (op == OP_ALLOC) begin
				for (int i = 0; i < int'(n_blocks) && !found; i++) begin
					if (blk_free[i] && blk_len[i] >= need) begin
						blk_free[i] = 1'b0;
						r.address = user_addr(i);
						found = 1'b1;
					end
				end
				if (!found) begin
					if (n_blocks >= BLOCKS) begin
						r.status = ST_TABLE_FULL;
					end else if (brk + need > HEAP) begin
						r.status = ST_EXHAUSTED;
					end else begin
						blk_off[n_blocks] = 16'(brk);
						blk_len[n_blocks] = 17'(need);
						blk_free[n_blocks] = 1'b0;
						r.address = user_addr(n_blocks);
						n_blocks++;
						brk += need;
					end
				end
			end else begin
				r.status = ST_UNKNOWN;
				for (int i = 0; i < int'(n_blocks) && r.status == ST_UNKNOWN; i++) begin
					if (user_addr(i) == fa) begin
						blk_free[i] = 1'b1;
						r.status = ST_OK;
					end
				end
			end
			pending_q.push_back(r);
		endfunction

		task check_result(logic [31:0] addr, logic [1:0] st);
			heap_result_t want;
			if (pending_q.size() == 0) begin
				report($sformatf("unexpected result address %h status %0d", addr, st));
			end else begin
				want = pending_q.pop_front();
				if (addr !== want.address)
					report($sformatf("address %h, expected %h", addr, want.address));
				if (st !== want.status)
					report($sformatf("status %0d, expected %0d", st, want.status));
			end
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [31:0] cfg_wdata;
	logic        start;
	logic        busy;
	logic        operation;
	logic [15:0] request_bytes;
	logic [31:0] free_address;
	logic        done;
	logic [31:0] address;
	logic [1:0]  status;

	heap_scoreboard sb;
	int unsigned    idle_pct;

	first_fit_heap_allocator_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.start(start),
		.busy(busy),
		.operation(operation),
		.request_bytes(request_bytes),
		.free_address(free_address),
		.done(done),
		.address(address),
		.status(status)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(address, status);
	end

	task automatic send(input logic op, input logic [15:0] req, input logic [31:0] fa);
		bit accepted;
		accepted = 1'b0;
		operation <= op;
		request_bytes <= req;
		free_address <= fa;
		while (!accepted) begin
			if (idle_pct != 0 && $urandom_range(99) < idle_pct)
				start <= 1'b0;
			else
				start <= 1'b1;
			@(posedge clk);
			accepted = start && !busy;
		end
		sb.note_request(op, req, fa);
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (sb.pending_q.size() != 0 || busy);
	endtask

	task automatic write_base(input logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.base = value;
	endtask

	task automatic random_item();
		logic [15:0] req;
		logic [31:0] fa;
		int unsigned room;
		int unsigned roll;
		req = 16'($urandom);
		fa = $urandom;
		room = HEAP - sb.brk;
		roll = $urandom_range(99);
		if ($urandom_range(99) < 42) begin
			if (sb.n_blocks != 0 && roll < 80) begin
				fa = sb.user_addr($urandom_range(sb.n_blocks - 1));
				if (roll >= 70)
					fa = fa + 32'd1;
			end
			send(OP_FREE, req, fa);
		end else begin
			// The last table slot is where an exact fit of the remaining heap, or one byte past it, can be tried
			// without starving the table of entries.
			if (sb.n_blocks == BLOCKS - 1 && roll < 50 && room >= HDR)
				req = 16'(room - HDR + $urandom_range(1));
			else if (roll < 80)
				req = 16'($urandom_range(191));
			else if (roll < 90)
				req = 16'($urandom_range(2047, 192));
			else
				req = 16'($urandom_range(65535, room > HDR ? room - HDR + 1 : 0));
			send(OP_ALLOC, req, fa);
		end
	endtask

	initial begin
		logic [31:0] bases [4];
		int unsigned idles [4];
		bases = '{32'h0000_0000, $urandom, 32'hFFFF_FFF8, $urandom};
		idles = '{0, 45, 0, 15};
		sb = new();
		idle_pct = 0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		start <= 1'b0;
		operation <= OP_ALLOC;
		request_bytes <= '0;
		free_address <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// With the base at its top value every user address wraps past zero.
		write_base(32'hFFFF_FFFF);
		send(OP_FREE, 16'h0000, 32'h0000_0000);
		send(OP_ALLOC, 16'hFFFF, 32'hFFFF_FFFF);
		send(OP_ALLOC, 16'd0, 32'h0);
		send(OP_ALLOC, 16'd1, 32'h0);
		send(OP_ALLOC, 16'd16, 32'h0);
		send(OP_FREE, 16'h0, sb.user_addr(1));
		send(OP_FREE, 16'h0, sb.user_addr(1));
		send(OP_ALLOC, 16'd0, 32'h0);
		send(OP_FREE, 16'h0, sb.user_addr(0));
		send(OP_FREE, 16'h0, sb.user_addr(2));
		send(OP_ALLOC, 16'd16, 32'h0);
		send(OP_ALLOC, 16'd1, 32'h0);
		send(OP_FREE, 16'h0, sb.user_addr(3) + 32'd1);
		send(OP_FREE, 16'h0, 32'hFFFF_FFFF);
		send(OP_ALLOC, 16'hFFF7, 32'h0);
		send(OP_FREE, 16'h0, sb.user_addr(1));
		send(OP_ALLOC, 16'd0, 32'h0);
		drain();

		for (int p = 0; p < 4; p++) begin
			write_base(bases[p]);
			idle_pct = idles[p];
			repeat (450) random_item();
			drain();
		end

		repeat (300) @(posedge clk);
		if (sb.errors == 0)
			$display("tb_first_fit_heap_allocator_core OK");
		else
			$display("tb_first_fit_heap_allocator_core NOT OK");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb_first_fit_heap_allocator_core NOT OK");
		$finish;
	end

endmodule

// File: filelist.f
sv/ffha_pkg.sv
sv/ffha_table.sv
sv/first_fit_heap_allocator_core.sv
test/tb_first_fit_heap_allocator_core.sv
